>>> hw/rtl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by modexp_mulmod and modular_exponentiation.
package modexp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

  localparam word_t WORD_ONE = word_t'(1);

  // multiplier request from the sequencer
  typedef struct packed {
    logic start;
  } mm_req_t;

  // multiplier status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

>>> hw/rtl/modexp_mulmod.sv
// Bit-serial modular multiplier: product = (op_a * op_b) mod modulus.
// Needs op_a <= modulus. Depends on modexp_pkg.
module modexp_mulmod
  import modexp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mm_req_t  req,
  input  word_t    op_a,
  input  word_t    op_b,
  input  word_t    modulus,
  output mm_stat_t stat,
  output word_t    product
);

  word_t            a;
  word_t            b;
  word_t            m;
  word_t            r;
  word_t            r_next;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DATA_WIDTH+1:0] s;
  logic [DATA_WIDTH+1:0] m1;
  logic [DATA_WIDTH+1:0] m2;

  // r <- (2r + bit*a) mod m, MSB of b first; 2r + a < 3m
  always_comb begin
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    s  = {1'b0, r, 1'b0} + (b[DATA_WIDTH-1] ? {2'b00, a} : '0);
    if (s >= m2) begin
      r_next = word_t'(s - m2);
    end else if (s >= m1) begin
      r_next = word_t'(s - m1);
    end else begin
      r_next = word_t'(s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= op_a;
      b <= op_b;
      m <= modulus;
      r <= '0;
    end else if (busy) begin
      r <= r_next;
      b <= {b[DATA_WIDTH-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = r;

endmodule

>>> hw/rtl/modular_exponentiation.sv
// Top level: base^exponent mod modulus, right-to-left square-and-multiply.
// Depends on modexp_pkg and modexp_mulmod.
//
//   channel  | handshake            | word
//   ---------+----------------------+-------------------------------
//   input    | in_valid / in_ready  | base_value, exponent
//   output   | out_valid / out_ready| power_result
//   config   | cfg_we               | cfg_data (modulus, zero ignored)
//
// One word at a time. The single bit-serial modular multiplier sets the
// pace: one product to reduce the base, then per exponent bit a decision
// step, a multiply (set bits only) and a square; the square after the top
// set bit is skipped. A zero exponent skips every product. Reset (rst,
// synchronous) sets the modulus to 1 and empties the block. A finished
// result waits in the output register; the next word is accepted meanwhile.
module modular_exponentiation
  import modexp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  word_t base_value,
  input  word_t exponent,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t power_result,
  input  logic  cfg_we,
  input  word_t cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;  // base mod m
  localparam logic [2:0] S_STEP = 3'd2;  // pick next operation
  localparam logic [2:0] S_MUL  = 3'd3;  // acc * base
  localparam logic [2:0] S_SQR  = 3'd4;  // base * base
  localparam logic [2:0] S_FIN  = 3'd5;  // hand acc to output register

  logic [2:0] state;
  word_t      modulus;
  word_t      base;
  word_t      acc;
  word_t      ex;

  mm_req_t  mm_req;
  mm_stat_t mm_stat;
  word_t    op_a;
  word_t    op_b;
  word_t    mm_prod;
  logic     accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // multiplier launches: reduce on accept, multiply/square from STEP,
  // square right after a multiply unless no exponent bits remain
  always_comb begin
    mm_req.start = 1'b0;
    case (state)
      S_IDLE:  mm_req.start = accept && (exponent != '0);
      S_STEP:  mm_req.start = (ex != '0);
      S_MUL:   mm_req.start = mm_stat.done && (ex[DATA_WIDTH-1:1] != '0);
      default: mm_req.start = 1'b0;
    endcase
  end

  // reduction runs as 1 * base_value, so op_a <= modulus always holds
  assign op_a = (state == S_IDLE) ? WORD_ONE : base;
  assign op_b = (state == S_IDLE) ? base_value :
                ((state == S_STEP) && ex[0]) ? acc : base;

  modexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .req     (mm_req),
    .op_a    (op_a),
    .op_b    (op_b),
    .modulus (modulus),
    .stat    (mm_stat),
    .product (mm_prod)
  );

  // modulus register, zero writes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WORD_ONE;
    end else if (cfg_we && (cfg_data != '0)) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (exponent == '0) ? S_FIN : S_RED;
          end
        end
        S_RED: begin
          if (mm_stat.done) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (ex == '0) begin
            state <= S_FIN;
          end else if (ex[0]) begin
            state <= S_MUL;
          end else begin
            state <= S_SQR;
          end
        end
        S_MUL: begin
          if (mm_stat.done) begin
            state <= (ex[DATA_WIDTH-1:1] != '0) ? S_SQR : S_FIN;
          end
        end
        S_SQR: begin
          if (mm_stat.done) begin
            state <= S_STEP;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          base <= base_value;
          ex   <= exponent;
          acc  <= WORD_ONE;
        end
      end
      S_RED: begin
        if (mm_stat.done) begin
          base <= mm_prod;
        end
      end
      S_MUL: begin
        if (mm_stat.done) begin
          acc <= mm_prod;
          ex  <= {ex[DATA_WIDTH-1:1], 1'b0};
        end
      end
      S_SQR: begin
        if (mm_stat.done) begin
          base <= mm_prod;
          ex   <= {1'b0, ex[DATA_WIDTH-1:1]};
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && (!out_valid || out_ready)) begin
      power_result <= acc;
    end
  end

  // ---- assertions ----
  a_mod_nonzero: assert property (@(posedge clk) disable iff (rst)
    modulus != '0)
    else $error("modulus register is zero");

  a_prod_reduced: assert property (@(posedge clk) disable iff (rst)
    mm_stat.done |-> (mm_prod < modulus))
    else $error("multiplier result not reduced");

  a_done_owned: assert property (@(posedge clk) disable iff (rst)
    mm_stat.done |-> (state == S_RED || state == S_MUL || state == S_SQR))
    else $error("multiplier finished with no operation pending");

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    mm_req.start |-> !mm_stat.busy)
    else $error("multiplier launched while busy");

  a_zero_exp: assert property (@(posedge clk) disable iff (rst)
    (accept && exponent == '0) |=> (state == S_FIN && acc == WORD_ONE))
    else $error("zero exponent did not go straight to result");

endmodule

>>> bench/tb.sv
// Self-checking bench for modular_exponentiation: base^exponent mod modulus.
// Needs modexp_pkg and the RTL below it. A directed table comes first, then
// random words under three idling patterns. Each word is checked against a hand-worked answer or a predictor.
`timescale 1ns / 1ps

module tb;
  import modexp_pkg::*;

  // One row of the directed table. When set_mod is high the modulus is
  // loaded (after the block drains) before the word goes out. Rows with
  // known set carry a hand-worked answer; the rest go through mod_power.
  typedef struct packed {
    logic  set_mod;
    word_t mod_val;
    word_t base;
    word_t expo;
    logic  known;
    word_t want;
  } vector_row_t;

  localparam int NUM_ROWS   = 22;
  localparam int RAND_WORDS = 89;   // per idling phase, three phases
  localparam int SEGMENT    = 24;   // random words between modulus changes
  localparam int DRAIN_WAIT = 2200; // cycles watched after the drain for stray answers

  localparam vector_row_t DIRECTED [NUM_ROWS] = '{
    // modulus after reset is 1: zero exponent still answers 1
    '{1'b0, 32'h0000_0000, 32'h0000_0005, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{1'b0, 32'h0000_0000, 32'h0000_0007, 32'h0000_0003, 1'b1, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
    // largest modulus; 0xFFFFFFFE is -1 here
    '{1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0005, 1'b1, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0001, 1'b1, 32'hFFFF_FFFE},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0002, 1'b1, 32'h0000_0001},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE},
    '{1'b0, 32'h0000_0000, 32'h0000_0002, 32'h0000_001F, 1'b1, 32'h8000_0000},
    '{1'b0, 32'h0000_0000, 32'h0000_0002, 32'h0000_0020, 1'b1, 32'h0000_0001},
    '{1'b0, 32'h0000_0000, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    // zero modulus must be dropped, 0xFFFFFFFF stays in force
    '{1'b1, 32'h0000_0000, 32'h0000_0003, 32'h0000_0002, 1'b1, 32'h0000_0009},
    // modulus 2
    '{1'b1, 32'h0000_0002, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0003, 1'b1, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'h0000_0003, 32'h0000_0000, 1'b1, 32'h0000_0001},
    // power-of-two modulus, base above it
    '{1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0002, 1'b1, 32'h0000_0001},
    '{1'b0, 32'h0000_0000, 32'hDEAD_BEEF, 32'h8000_0000, 1'b0, 32'h0000_0000},
    // largest 32-bit prime: Fermat gives 1, base equal to modulus gives 0
    '{1'b1, 32'hFFFF_FFFB, 32'h7FFF_FFFF, 32'hFFFF_FFFA, 1'b1, 32'h0000_0001},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFB, 32'h0000_0007, 1'b1, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001}
  };

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  word_t base_value;
  word_t exponent;
  logic  out_valid;
  logic  out_ready;
  word_t power_result;
  logic  cfg_we;
  word_t cfg_data;

  word_t expected_powers[$];   // answers for accepted words, oldest first
  word_t modulus_shadow;       // what the modulus register should hold
  int    mismatch_count;
  int    send_idle_pct;        // chance per cycle that the sender holds off
  int    recv_idle_pct;        // chance per cycle that out_ready is low

  modular_exponentiation DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .base_value  (base_value),
    .exponent    (exponent),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .power_result(power_result),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // Right-to-left square-and-multiply at 64 bits. Operands stay below 2^32,
  // so every product fits and the remainder is exact. The base is left
  // unreduced; the first product takes care of it.
  function automatic word_t mod_power(input word_t b, input word_t e, input word_t m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] md;
    word_t       bits;
    acc  = 64'd1;
    sq   = {32'd0, b};
    md   = {32'd0, m};
    bits = e;
    while (bits != '0) begin
      if (bits[0]) begin
        acc = (acc * sq) % md;
      end
      sq   = (sq * sq) % md;
      bits = bits >> 1;
    end
    return word_t'(acc);
  endfunction

  // Load a new modulus. The block must be idle: stop sending, wait for every
  // outstanding answer, give it a few spare cycles, then pulse cfg_we.
  task automatic load_modulus(input word_t value);
    in_valid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    // a zero write is dropped by the block
    if (value != '0) begin
      modulus_shadow = value;
    end
  endtask

  // Offer one word and hold it until accepted. Entered and left on a clock
  // edge; in_valid stays high on exit so back-to-back words need no toggle.
  task automatic send_word(input word_t b, input word_t e, input logic known,
                           input word_t want);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    base_value <= b;
    exponent   <= e;
    // in_ready read here is the value from before the edge
    do @(posedge clk); while (!in_ready);
    expected_powers.push_back(known ? want : mod_power(b, e, modulus_shadow));
  endtask

  // Receiver: out_ready toggles at random at the current idle rate.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result check: every accepted answer is matched with the oldest word.
  always @(posedge clk) begin
    word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_powers.size() == 0) begin
        $error("unexpected answer: power_result actual %h", power_result);
        mismatch_count++;
      end else begin
        want = expected_powers.pop_front();
        if (power_result !== want) begin
          $error("power_result expected %h actual %h", want, power_result);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    word_t b;
    word_t e;
    word_t m;
    int    phase;
    int    n;

    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    base_value     = '0;
    exponent       = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    mismatch_count = 0;
    modulus_shadow = WORD_ONE;
    send_idle_pct  = 22;
    recv_idle_pct  = 67;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, run under the first idling pattern.
    for (n = 0; n < NUM_ROWS; n++) begin
      if (DIRECTED[n].set_mod) begin
        load_modulus(DIRECTED[n].mod_val);
      end
      send_word(DIRECTED[n].base, DIRECTED[n].expo, DIRECTED[n].known,
                DIRECTED[n].want);
    end

    // Random words. Phase 0: sender idles lightly, receiver heavily;
    // phase 1: the reverse; phase 2: full throughput on both sides.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 67 : 0;
      recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 22 : 0;
      for (n = 0; n < RAND_WORDS; n++) begin
        if (n % SEGMENT == 0) begin
          // Moduli: extremes, small odd and even values, powers of two,
          // wide values with the top bit set, and a dropped zero write.
          case ($urandom_range(0, 9))
            0:       m = WORD_ONE;
            1:       m = 32'd2;
            2, 3:    m = 32'hFFFF_FFFF;
            4:       m = $urandom_range(3, 255);
            5:       m = word_t'(1) << $urandom_range(0, 31);
            6:       m = '0;
            7:       m = $urandom | 32'h8000_0000;
            default: m = $urandom;
          endcase
          load_modulus(m);
        end
        case ($urandom_range(0, 9))
          0:       b = '0;
          1:       b = WORD_ONE;
          2:       b = 32'hFFFF_FFFF;
          3:       b = modulus_shadow - $urandom_range(0, 2);
          4:       b = modulus_shadow + $urandom_range(0, 2);
          default: b = $urandom;
        endcase
        // Long exponents are slow, so most are short.
        case ($urandom_range(0, 15))
          0:          e = '0;
          1, 2:       e = $urandom_range(1, 16);
          3:          e = 32'hFFFF_FFFF;
          4, 5:       e = $urandom;
          6:          e = 32'h8000_0000 | $urandom;
          default:    e = $urandom >> $urandom_range(8, 28);
        endcase
        send_word(b, e, 1'b0, '0);
      end
    end

    // Drain, then watch a while longer for stray answers.
    in_valid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every word at full exponent
  // length plus receiver stalls).
  initial begin
    #12_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
